/* design/clot_pkg.sv */
// clot_pkg: shared types, codes and defaults of the chunk load order tracker
// used by clot_front, clot_back and chunk_load_order_tracker; no dependencies
package clot_pkg;

    // default sizes
    localparam int NUM_CHUNKS_DEF    = 1024;
    localparam int PENDING_DEPTH_DEF = 16;

    // configuration register indexes
    localparam logic CFG_CHUNK_SIZE  = 1'b0;
    localparam logic CFG_MAX_PENDING = 1'b1;

    // configuration reset values
    localparam logic [16:0] CHUNK_SIZE_RST  = 17'd1024;
    localparam logic [4:0]  MAX_PENDING_RST = 5'd16;

    // request codes
    typedef enum logic [1:0] {
        REQ_LOAD_NEXT = 2'd0,
        REQ_QUERY     = 2'd1,
        REQ_ENQUEUE   = 2'd2,
        REQ_MARK      = 2'd3
    } req_type_t;

    // one queued request
    typedef struct packed {
        req_type_t   typ;
        logic [31:0] idx;
    } q_entry_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_EXEC,
        ST_BMRD,
        ST_SKIP_RD,
        ST_SKIP_CHK,
        ST_MUL,
        ST_FIN
    } back_state_t;

endpackage

/* design/clot_front.sv */
// clot_front: input acceptance and two-entry request queue
// depends on clot_pkg for the queue entry type
module clot_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [31:0]       range_index,
    input  logic              clear_busy,
    output logic              q_valid,
    output clot_pkg::q_entry_t q_entry,
    input  logic              q_pop
);

    clot_pkg::q_entry_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    clot_pkg::q_entry_t new_entry;

    // classify the incoming request
    always_comb
    begin
        new_entry.typ = clot_pkg::req_type_t'(req_type);
        new_entry.idx = range_index;
    end

    assign in_ready = (count_reg != 2'd2) && !clear_busy;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = fifo_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

/* design/clot_back.sv */
// clot_back: sequencer that divides, scans pending slots, walks the loaded
// bitmap and drives the result register; depends on clot_pkg
module clot_back #(
    parameter int NUM_CHUNKS    = clot_pkg::NUM_CHUNKS_DEF,
    parameter int PENDING_DEPTH = clot_pkg::PENDING_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [16:0]        chunk_size,
    input  logic [4:0]         max_pending,
    input  logic               q_valid,
    input  clot_pkg::q_entry_t q_entry,
    output logic               q_pop,
    output logic               clear_busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        chunk_start,
    output logic               is_loaded,
    output logic               is_loading,
    output logic               accepted
);

    localparam int CW  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int SW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int SCW = $clog2(PENDING_DEPTH + 1);
    localparam int LW  = (SCW > 5) ? SCW : 5;

    clot_pkg::back_state_t state_reg, state_next;

    // request and divider
    clot_pkg::req_type_t typ_reg;
    logic [31:0] idx_reg;
    logic [31:0] quot_reg;
    logic [16:0] rem_reg;
    logic [4:0]  div_cnt_reg;

    // scan results
    logic [SW-1:0]  scan_cnt_reg;
    logic [SCW-1:0] pcount_reg;
    logic           best_found_reg;
    logic [SW-1:0]  best_idx_reg;
    logic [CW-1:0]  best_chunk_reg;
    logic           match_reg;
    logic           free_found_reg;
    logic [SW-1:0]  free_idx_reg;

    // tracker state
    logic [CW:0]    cursor_reg;
    logic [CW-1:0]  loading_chunk_reg;
    logic           loading_valid_reg;
    logic [CW-1:0]  pend_chunk_reg [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] pend_valid_reg;

    // bitmap memory
    logic           bitmap_mem [NUM_CHUNKS];
    logic           bm_rdata_reg;
    logic           bm_we, bm_wdata, bm_re;
    logic [CW-1:0]  bm_waddr, bm_raddr;
    logic [CW-1:0]  clr_cnt_reg;

    // multiplier and result
    logic [CW-1:0]  mul_a_reg;
    logic [48:0]    prod;
    logic           is_ld_reg;
    logic [31:0]    res_start_reg;
    logic           res_loaded_reg, res_loading_reg, res_acc_reg;
    logic           out_valid_reg;
    logic [31:0]    out_start_reg;
    logic           out_loaded_reg, out_loading_reg, out_acc_reg;

    // decoded helpers
    logic [16:0]    eff;
    logic [17:0]    trial;
    logic           trial_ge;
    logic           in_range;
    logic [CW-1:0]  c_low;
    logic           c_is_ld;
    logic [LW-1:0]  limit;
    logic           enq_ok;
    logic           mark_ok;
    logic           cursor_live;
    logic           out_load;
    logic [CW-1:0]  scan_chunk;
    logic           scan_valid;

    assign eff         = (chunk_size == 17'd0) ? 17'd1 : chunk_size;
    assign trial       = {rem_reg, quot_reg[31]};
    assign trial_ge    = trial >= {1'b0, eff};
    assign in_range    = quot_reg < 32'(NUM_CHUNKS);
    assign c_low       = quot_reg[CW-1:0];
    assign c_is_ld     = loading_valid_reg && (loading_chunk_reg == c_low);
    assign limit       = (LW'(max_pending) < LW'(PENDING_DEPTH)) ? LW'(max_pending)
                                                                 : LW'(PENDING_DEPTH);
    assign enq_ok      = in_range && (LW'(pcount_reg) < limit) && !c_is_ld && !match_reg;
    assign mark_ok     = in_range && (quot_reg > 32'(cursor_reg));
    assign cursor_live = cursor_reg < (CW+1)'(NUM_CHUNKS);
    assign scan_chunk  = pend_chunk_reg[scan_cnt_reg];
    assign scan_valid  = pend_valid_reg[scan_cnt_reg];
    assign prod        = 49'(mul_a_reg) * 49'(eff);
    assign out_load    = (state_reg == clot_pkg::ST_FIN) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clot_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CW'(NUM_CHUNKS - 1))
                begin
                    state_next = clot_pkg::ST_IDLE;
                end
            end
            clot_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_entry.typ == clot_pkg::REQ_LOAD_NEXT)
                                 ? clot_pkg::ST_SCAN : clot_pkg::ST_DIV;
                end
            end
            clot_pkg::ST_DIV:
            begin
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = clot_pkg::ST_SCAN;
                end
            end
            clot_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == SW'(PENDING_DEPTH - 1))
                begin
                    state_next = clot_pkg::ST_EXEC;
                end
            end
            clot_pkg::ST_EXEC:
            begin
                unique case (typ_reg)
                    clot_pkg::REQ_LOAD_NEXT:
                    begin
                        if (best_found_reg)
                        begin
                            state_next = clot_pkg::ST_MUL;
                        end
                        else if (cursor_live)
                        begin
                            state_next = clot_pkg::ST_SKIP_RD;
                        end
                        else
                        begin
                            state_next = clot_pkg::ST_FIN;
                        end
                    end
                    clot_pkg::REQ_QUERY:
                    begin
                        state_next = in_range ? clot_pkg::ST_BMRD : clot_pkg::ST_FIN;
                    end
                    default:
                    begin
                        state_next = clot_pkg::ST_FIN;
                    end
                endcase
            end
            clot_pkg::ST_BMRD:
            begin
                state_next = clot_pkg::ST_FIN;
            end
            clot_pkg::ST_SKIP_RD:
            begin
                state_next = cursor_live ? clot_pkg::ST_SKIP_CHK : clot_pkg::ST_MUL;
            end
            clot_pkg::ST_SKIP_CHK:
            begin
                state_next = bm_rdata_reg ? clot_pkg::ST_SKIP_RD : clot_pkg::ST_MUL;
            end
            clot_pkg::ST_MUL:
            begin
                state_next = clot_pkg::ST_FIN;
            end
            clot_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = clot_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clot_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop      = 1'b0;
        clear_busy = 1'b0;
        bm_we      = 1'b0;
        bm_wdata   = 1'b0;
        bm_waddr   = c_low;
        bm_re      = 1'b0;
        bm_raddr   = c_low;
        unique case (state_reg)
            clot_pkg::ST_CLEAR:
            begin
                clear_busy = 1'b1;
                bm_we      = 1'b1;
                bm_waddr   = clr_cnt_reg;
            end
            clot_pkg::ST_IDLE:
            begin
                q_pop = q_valid;
            end
            clot_pkg::ST_EXEC:
            begin
                if (typ_reg == clot_pkg::REQ_QUERY && in_range)
                begin
                    bm_re = 1'b1;
                end
                if (typ_reg == clot_pkg::REQ_MARK && mark_ok)
                begin
                    bm_we    = 1'b1;
                    bm_wdata = 1'b1;
                end
            end
            clot_pkg::ST_SKIP_RD:
            begin
                bm_re    = cursor_live;
                bm_raddr = cursor_reg[CW-1:0];
            end
            clot_pkg::ST_SKIP_CHK:
            begin
                bm_we    = bm_rdata_reg;
                bm_waddr = cursor_reg[CW-1:0];
            end
            default:
            begin
                bm_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= clot_pkg::ST_CLEAR;
            clr_cnt_reg       <= '0;
            cursor_reg        <= '0;
            loading_chunk_reg <= '0;
            loading_valid_reg <= 1'b0;
            pend_valid_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == clot_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (state_reg == clot_pkg::ST_EXEC && typ_reg == clot_pkg::REQ_LOAD_NEXT)
            begin
                if (best_found_reg)
                begin
                    pend_valid_reg[best_idx_reg] <= 1'b0;
                    loading_chunk_reg            <= best_chunk_reg;
                    loading_valid_reg            <= 1'b1;
                    if ((CW+1)'(best_chunk_reg) == cursor_reg)
                    begin
                        cursor_reg <= cursor_reg + (CW+1)'(1);
                    end
                end
                else if (cursor_live)
                begin
                    loading_chunk_reg <= cursor_reg[CW-1:0];
                    loading_valid_reg <= 1'b1;
                    cursor_reg        <= cursor_reg + (CW+1)'(1);
                end
            end
            if (state_reg == clot_pkg::ST_EXEC && typ_reg == clot_pkg::REQ_ENQUEUE && enq_ok)
            begin
                pend_valid_reg[free_idx_reg] <= 1'b1;
            end
            if (state_reg == clot_pkg::ST_SKIP_CHK && bm_rdata_reg)
            begin
                cursor_reg <= cursor_reg + (CW+1)'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            clot_pkg::ST_IDLE:
            begin
                typ_reg         <= q_entry.typ;
                idx_reg         <= q_entry.idx;
                quot_reg        <= q_entry.idx;
                rem_reg         <= '0;
                div_cnt_reg     <= '0;
                scan_cnt_reg    <= '0;
                pcount_reg      <= '0;
                best_found_reg  <= 1'b0;
                match_reg       <= 1'b0;
                free_found_reg  <= 1'b0;
                res_start_reg   <= '0;
                res_loaded_reg  <= 1'b0;
                res_loading_reg <= 1'b0;
                res_acc_reg     <= 1'b0;
            end
            clot_pkg::ST_DIV:
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                quot_reg    <= {quot_reg[30:0], trial_ge};
                rem_reg     <= trial_ge ? 17'(trial - {1'b0, eff}) : trial[16:0];
            end
            clot_pkg::ST_SCAN:
            begin
                scan_cnt_reg <= scan_cnt_reg + SW'(1);
                if (scan_valid)
                begin
                    pcount_reg <= pcount_reg + SCW'(1);
                    if (scan_chunk == c_low)
                    begin
                        match_reg <= 1'b1;
                    end
                    if (!best_found_reg || scan_chunk < best_chunk_reg)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= scan_cnt_reg;
                        best_chunk_reg <= scan_chunk;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= scan_cnt_reg;
                end
            end
            clot_pkg::ST_EXEC:
            begin
                if (typ_reg != clot_pkg::REQ_LOAD_NEXT)
                begin
                    res_start_reg <= idx_reg - 32'(rem_reg);
                end
                unique case (typ_reg)
                    clot_pkg::REQ_LOAD_NEXT:
                    begin
                        mul_a_reg   <= best_found_reg ? best_chunk_reg : cursor_reg[CW-1:0];
                        res_acc_reg <= best_found_reg || cursor_live;
                    end
                    clot_pkg::REQ_QUERY:
                    begin
                        is_ld_reg       <= c_is_ld;
                        res_acc_reg     <= in_range;
                        res_loading_reg <= in_range && (c_is_ld || match_reg);
                    end
                    clot_pkg::REQ_ENQUEUE:
                    begin
                        res_acc_reg <= enq_ok;
                        if (enq_ok)
                        begin
                            pend_chunk_reg[free_idx_reg] <= c_low;
                        end
                    end
                    default:
                    begin
                        res_acc_reg <= mark_ok;
                    end
                endcase
            end
            clot_pkg::ST_BMRD:
            begin
                res_loaded_reg <= ((quot_reg < 32'(cursor_reg)) && !is_ld_reg) || bm_rdata_reg;
            end
            clot_pkg::ST_MUL:
            begin
                res_start_reg <= prod[31:0];
            end
            clot_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    out_start_reg   <= res_start_reg;
                    out_loaded_reg  <= res_loaded_reg;
                    out_loading_reg <= res_loading_reg;
                    out_acc_reg     <= res_acc_reg;
                end
            end
            default:
            begin
                div_cnt_reg <= div_cnt_reg;
            end
        endcase
    end

    // loaded-ahead bitmap
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bitmap_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rdata_reg <= bitmap_mem[bm_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign chunk_start = out_start_reg;
    assign is_loaded   = out_loaded_reg;
    assign is_loading  = out_loading_reg;
    assign accepted    = out_acc_reg;

    // checks
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clot_pkg::ST_CLEAR) |-> !q_pop)
        else $error("queue popped during bitmap clear");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= (CW+1)'(NUM_CHUNKS))
        else $error("cursor beyond chunk count");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result not presented after load");

    a_enq_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clot_pkg::ST_EXEC && typ_reg == clot_pkg::REQ_ENQUEUE && enq_ok)
        |-> (free_found_reg && !pend_valid_reg[free_idx_reg]))
        else $error("enqueue into an occupied slot");

endmodule

/* design/chunk_load_order_tracker.sv */
// Chunk load order tracker: a request goes from the two-entry queue to the divider, the
// pending-slot scan, the execute step and the result register; a query in range also reads
// the bitmap, and load next skips the divider and may walk loaded-ahead chunks before the
// start multiply. The back end takes one item at a time, through the one-bit-a-cycle divider
// and the one-slot-a-cycle pending scan, and starts the next only after its result is loaded;
// a held result stalls the back end. After reset the loaded bitmap is cleared entry by entry
// with no input taken; configuration registers reset to chunk size 1024 and pending limit 16.
module chunk_load_order_tracker #(
    parameter int NUM_CHUNKS    = clot_pkg::NUM_CHUNKS_DEF,
    parameter int PENDING_DEPTH = clot_pkg::PENDING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] range_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] chunk_start,
    output logic        is_loaded,
    output logic        is_loading,
    output logic        accepted
);

    logic [16:0] chunk_size_reg;
    logic [4:0]  max_pending_reg;
    logic               q_valid, q_pop, clear_busy;
    clot_pkg::q_entry_t q_entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg  <= clot_pkg::CHUNK_SIZE_RST;
            max_pending_reg <= clot_pkg::MAX_PENDING_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                clot_pkg::CFG_CHUNK_SIZE:  chunk_size_reg  <= cfg_data;
                clot_pkg::CFG_MAX_PENDING: max_pending_reg <= cfg_data[4:0];
                default:                   chunk_size_reg  <= chunk_size_reg;
            endcase
        end
    end

    // front end: accept and queue
    clot_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .range_index (range_index),
        .clear_busy  (clear_busy),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop)
    );

    // back end: execute
    clot_back #(
        .NUM_CHUNKS    (NUM_CHUNKS),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_size  (chunk_size_reg),
        .max_pending (max_pending_reg),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .clear_busy  (clear_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .chunk_start (chunk_start),
        .is_loaded   (is_loaded),
        .is_loading  (is_loading),
        .accepted    (accepted)
    );

endmodule

/* tb/sv/clot_checker.sv */
// clot_checker: watches the request and result channels of the chunk load order tracker,
// predicts every result and compares all of its fields; depends on clot_pkg
module clot_checker #(
    parameter int NUM_CHUNKS    = clot_pkg::NUM_CHUNKS_DEF,
    parameter int PENDING_DEPTH = clot_pkg::PENDING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] range_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] chunk_start,
    input  logic        is_loaded,
    input  logic        is_loading,
    input  logic        accepted,
    output int          errors,
    output int          outstanding,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import clot_pkg::*;

    typedef struct packed {
        logic [31:0] start;
        logic        loaded;
        logic        loading;
        logic        acc;
    } answer_t;

    // tracker state mirror
    logic [16:0] size_reg;
    logic [4:0]  limit_reg;
    int unsigned cursor;
    int unsigned cur_load;
    bit          cur_load_ok;
    int unsigned slot_chunk [PENDING_DEPTH];
    bit          slot_ok    [PENDING_DEPTH];
    bit          ahead      [NUM_CHUNKS];

    answer_t answers_due[$];

    function automatic logic [31:0] start_of(int unsigned c);
        logic [63:0] prod;
        prod = 64'(c) * 64'((size_reg == 0) ? 17'd1 : size_reg);
        return prod[31:0];
    endfunction

    function automatic bit chunk_waiting(int unsigned c);
        for (int i = 0; i < PENDING_DEPTH; i++)
            if (slot_ok[i] && slot_chunk[i] == c)
                return 1;
        return 0;
    endfunction

    // advance the mirror by one request and return the expected answer
    function automatic answer_t track_request(req_type_t typ, logic [31:0] idx);
        answer_t a;
        int unsigned sz, c, lim, cnt;
        int best;
        bit busy;
        a = '0;
        sz = (size_reg == 0) ? 1 : size_reg;
        c = idx / sz;
        if (typ == REQ_LOAD_NEXT) begin
            best = -1;
            for (int i = 0; i < PENDING_DEPTH; i++)
                if (slot_ok[i] && (best < 0 || slot_chunk[i] < slot_chunk[best]))
                    best = i;
            if (best >= 0) begin
                slot_ok[best] = 0;
                cur_load = slot_chunk[best];
                cur_load_ok = 1;
                if (cur_load == cursor && cursor < NUM_CHUNKS)
                    cursor++;
                a.start = start_of(cur_load);
                a.acc = 1;
            end
            else if (cursor < NUM_CHUNKS) begin
                cur_load = cursor;
                cur_load_ok = 1;
                a.start = start_of(cursor);
                a.acc = 1;
                cursor++;
                while (cursor < NUM_CHUNKS && ahead[cursor]) begin
                    ahead[cursor] = 0;
                    cursor++;
                end
            end
        end
        else begin
            a.start = start_of(c);
            busy = cur_load_ok && cur_load == c;
            if (c < NUM_CHUNKS) begin
                case (typ)
                    REQ_QUERY:
                    begin
                        a.acc = 1;
                        a.loaded = (c < cursor && !busy) || ahead[c];
                        a.loading = busy || chunk_waiting(c);
                    end
                    REQ_ENQUEUE:
                    begin
                        lim = (limit_reg < PENDING_DEPTH) ? limit_reg : PENDING_DEPTH;
                        cnt = 0;
                        for (int i = 0; i < PENDING_DEPTH; i++)
                            cnt += slot_ok[i];
                        if (cnt < lim && !busy && !chunk_waiting(c)) begin
                            for (int i = 0; i < PENDING_DEPTH; i++)
                                if (!slot_ok[i] && !a.acc) begin
                                    slot_ok[i] = 1;
                                    slot_chunk[i] = c;
                                    a.acc = 1;
                                end
                        end
                    end
                    default:
                    begin
                        if (c > cursor) begin
                            ahead[c] = 1;
                            a.acc = 1;
                        end
                    end
                endcase
            end
        end
        return a;
    endfunction

    // mirror update, prediction and comparison
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want, got;
        if (!rst_n) begin
            size_reg = CHUNK_SIZE_RST;
            limit_reg = MAX_PENDING_RST;
            cursor = 0;
            cur_load = 0;
            cur_load_ok = 0;
            for (int i = 0; i < PENDING_DEPTH; i++)
            begin
                slot_ok[i] = 0;
                slot_chunk[i] = 0;
            end
            for (int i = 0; i < NUM_CHUNKS; i++)
                ahead[i] = 0;
            answers_due.delete();
            errors <= 0;
            results_seen <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_CHUNK_SIZE)
                    size_reg = cfg_data;
                else
                    limit_reg = cfg_data[4:0];
            end
            if (in_valid && in_ready)
                answers_due.push_back(track_request(req_type_t'(req_type), range_index));
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                got = '{chunk_start, is_loaded, is_loading, accepted};
                if (answers_due.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected result start=%h acc=%b", $realtime,
                                 chunk_start, accepted);
                    errors <= errors + 1;
                end
                else begin
                    want = answers_due.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("%0t: mismatch exp start=%h ld=%b lg=%b acc=%b got start=%h ld=%b lg=%b acc=%b",
                                     $realtime, want.start, want.loaded, want.loading,
                                     want.acc, got.start, got.loaded, got.loading, got.acc);
                        errors <= errors + 1;
                    end
                end
            end
            outstanding <= answers_due.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus and verdict for the chunk load order tracker
// depends on clot_pkg, clot_checker and the tracker RTL
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clot_pkg::*;

    localparam int NCH = NUM_CHUNKS_DEF;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic        cfg_index = CFG_CHUNK_SIZE;
    logic [16:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_LOAD_NEXT;
    logic [31:0] range_index = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] chunk_start;
    logic        is_loaded, is_loading, accepted;
    int          errors, outstanding, results_seen;
    bit          calm = 0;
    logic [16:0] cur_size = CHUNK_SIZE_RST;

    always #10 clk = ~clk;

    chunk_load_order_tracker DUT (.*);

    clot_checker u_checker (.*);

    task automatic cfg_write(logic idx, logic [16:0] val);
        @(posedge clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_CHUNK_SIZE)
            cur_size = val;
        @(posedge clk);
        cfg_wr_en <= 0;
    endtask

    // one request transfer, with a random idle burst in front
    task automatic send_req(req_type_t t, logic [31:0] idx);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1;
        req_type <= t;
        range_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // range index inside chunk c at a random offset from its start
    function automatic logic [31:0] idx_near(int unsigned c);
        logic [63:0] base;
        int unsigned sz;
        sz = (cur_size == 0) ? 1 : cur_size;
        base = 64'(c) * sz + $urandom_range(0, sz - 1);
        return base[31:0];
    endfunction

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_phase(int n, int unsigned span);
        int unsigned r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_req(REQ_LOAD_NEXT, $urandom());
            else if (r < 50)
                send_req(REQ_QUERY, idx_near($urandom_range(0, span)));
            else if (r < 70)
                send_req(REQ_ENQUEUE, idx_near($urandom_range(0, span)));
            else if (r < 95)
                send_req(REQ_MARK, idx_near($urandom_range(0, span)));
            else
                send_req(req_type_t'($urandom_range(1, 3)), $urandom());
        end
    endtask

    // result side stalls in bursts
    always @(posedge clk)
    begin
        if (calm || $urandom_range(0, 3) != 0)
            out_ready <= 1;
        else begin
            out_ready <= 0;
            repeat ($urandom_range(0, 8)) @(posedge clk);
        end
    end

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (NCH + 20) @(posedge clk);

        // directed: every operation, extremes and out of range chunks
        send_req(REQ_QUERY, 32'h0);
        send_req(REQ_QUERY, 32'hFFFF_FFFF);
        send_req(REQ_ENQUEUE, 32'hFFFF_FFFF);
        send_req(REQ_MARK, 32'hFFFF_FFFF);
        send_req(REQ_MARK, 32'd0);
        send_req(REQ_MARK, 32'd2100);
        send_req(REQ_MARK, 32'd3072);
        send_req(REQ_ENQUEUE, 32'd5000);
        send_req(REQ_ENQUEUE, 32'd5000);
        send_req(REQ_ENQUEUE, 32'd0);
        send_req(REQ_LOAD_NEXT, 32'h0);
        send_req(REQ_LOAD_NEXT, 32'hFFFF_FFFF);
        send_req(REQ_LOAD_NEXT, 32'h0);
        send_req(REQ_QUERY, 32'd2047);
        send_req(REQ_QUERY, 32'd4100);
        send_req(REQ_QUERY, 32'd1023);
        send_req(REQ_ENQUEUE, 32'd1500);
        send_req(REQ_LOAD_NEXT, 32'h0);
        send_req(REQ_LOAD_NEXT, 32'h0);
        drain();

        // pending limit of zero and one, then full depth above the cap
        cfg_write(CFG_MAX_PENDING, 17'd0);
        send_req(REQ_ENQUEUE, 32'd40000);
        drain();
        cfg_write(CFG_MAX_PENDING, 17'd1);
        send_req(REQ_ENQUEUE, 32'd40000);
        send_req(REQ_ENQUEUE, 32'd50000);
        drain();
        cfg_write(CFG_MAX_PENDING, 17'd31);
        random_phase(150, 200);
        drain();

        // zero chunk size, unit size, small sizes walking to the end of the map
        cfg_write(CFG_CHUNK_SIZE, 17'd0);
        random_phase(150, NCH + 20);
        drain();
        cfg_write(CFG_CHUNK_SIZE, 17'd1);
        cfg_write(CFG_MAX_PENDING, 17'd4);
        random_phase(250, NCH + 20);
        drain();
        cfg_write(CFG_CHUNK_SIZE, 17'd3);
        cfg_write(CFG_MAX_PENDING, 17'd16);
        random_phase(250, NCH + 20);
        drain();
        // largest chunk sizes, 65536 and 131071
        cfg_write(CFG_CHUNK_SIZE, 17'd65536);
        random_phase(150, NCH + 20);
        drain();
        cfg_write(CFG_CHUNK_SIZE, 17'h1FFFF);
        random_phase(100, NCH + 20);
        drain();
        cfg_write(CFG_CHUNK_SIZE, 17'd777);
        cfg_write(CFG_MAX_PENDING, 17'd16);
        calm = 1;
        random_phase(280, NCH + 20);
        drain();

        $display("covered %0d results over chunk sizes 0 to 131071 and pending limits 0 to 31",
                 results_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
